@@ rtl/u8u16_pkg.sv @@
// shared types and constants for the utf-8 to utf-16 lossy decoder
// no dependencies; used by the decoder top level, the window and the decode unit
package u8u16_pkg;

    localparam int unsigned WIN_DEPTH = 4;
    localparam int unsigned CNT_W     = 3;

    localparam logic [15:0] C_REPL      = 16'hFFFD;
    localparam logic [20:0] C_MAX_CP    = 21'h10FFFF;
    localparam logic [20:0] C_SUPP_BASE = 21'h010000;
    localparam logic [15:0] C_SURR_HI   = 16'hD800;
    localparam logic [15:0] C_SURR_LO   = 16'hDC00;
    localparam logic [20:0] C_SURR_MIN  = 21'h00D800;
    localparam logic [20:0] C_SURR_MAX  = 21'h00DFFF;
    localparam logic [20:0] C_MIN_LEN2  = 21'h000080;
    localparam logic [20:0] C_MIN_LEN3  = 21'h000800;

    typedef logic [WIN_DEPTH-1:0][7:0] t_win;

    // outcome of one pass of the decode unit over the window head
    typedef enum logic [1:0] {
        K_EMPTY = 2'd0,
        K_WAIT  = 2'd1,
        K_EMIT1 = 2'd2,
        K_EMIT2 = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [15:0]      unit;
        logic [15:0]      unit_lo;
        logic [CNT_W-1:0] drop;
    } t_dec_res;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_LOW  = 3'b100
    } t_state;

endpackage

@@ rtl/utf8_to_utf16_lossy_decoder.sv @@
// a byte is taken while idle; each code unit is staged, then goes to the output register
// when the next unit is formed or the pass ends; one decode pass per cycle while the output
// register can take a word, and a surrogate pair goes through the low-surrogate state;
// the byte rate is set by the shared decode unit and the single output register; input
// is stalled while the window is being worked; reset: synchronous active low, clears
// sequencer, window count and output valid; held window bytes are not cleared
module utf8_to_utf16_lossy_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_unit,
    output logic        o_out_run_last,
    output logic        o_out_stream_last
);

    u8u16_pkg::t_state              r_state, n_state;
    u8u16_pkg::t_win                win_bytes;
    logic [u8u16_pkg::CNT_W-1:0]    win_count;
    u8u16_pkg::t_dec_res            dec;

    // staged word: held back one pass so that run_last is known when it leaves
    logic        r_sv, n_sv;
    logic [15:0] r_su, n_su;
    logic [15:0] r_lo, n_lo;
    logic        r_last, n_last;

    // output register
    logic        r_ov;
    logic [15:0] r_ou;
    logic        r_orl;
    logic        r_osl;

    logic        ofree;
    logic        push;
    logic        push_rl;
    logic        push_sl;
    logic        win_push;
    logic        win_drop;

    u8u16_win u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (win_push),
        .i_byte   (i_in_byte),
        .i_drop   (win_drop),
        .i_drop_n (dec.drop),
        .o_bytes  (win_bytes),
        .o_count  (win_count)
    );

    u8u16_dec u_dec (
        .i_bytes (win_bytes),
        .i_count (win_count),
        .i_last  (r_last),
        .o_res   (dec)
    );

    // output register can take a word this cycle
    assign ofree = !r_ov || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_sv     = r_sv;
        n_su     = r_su;
        n_lo     = r_lo;
        n_last   = r_last;
        push     = 1'b0;
        push_rl  = 1'b0;
        push_sl  = 1'b0;
        win_push = 1'b0;
        win_drop = 1'b0;

        unique case (r_state)
            u8u16_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    win_push = 1'b1;
                    n_last   = i_in_last;
                    n_state  = u8u16_pkg::ST_STEP;
                end
            end
            u8u16_pkg::ST_STEP: begin
                case (dec.kind) inside
                    u8u16_pkg::K_EMPTY, u8u16_pkg::K_WAIT: begin
                        // pass ends: the staged word is the last of this byte
                        if (!r_sv) begin
                            n_state = u8u16_pkg::ST_IDLE;
                        end else if (ofree) begin
                            push    = 1'b1;
                            push_rl = 1'b1;
                            push_sl = r_last;
                            n_sv    = 1'b0;
                            n_state = u8u16_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        if (!r_sv || ofree) begin
                            push     = r_sv;
                            n_sv     = 1'b1;
                            n_su     = dec.unit;
                            n_lo     = dec.unit_lo;
                            win_drop = 1'b1;
                            if (dec.kind == u8u16_pkg::K_EMIT2) begin
                                n_state = u8u16_pkg::ST_LOW;
                            end
                        end
                    end
                endcase
            end
            u8u16_pkg::ST_LOW: begin
                // high surrogate leaves, low surrogate is staged
                if (ofree) begin
                    push    = 1'b1;
                    n_su    = r_lo;
                    n_state = u8u16_pkg::ST_STEP;
                end
            end
            default: n_state = u8u16_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u8u16_pkg::ST_IDLE;
            r_sv    <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sv    <= n_sv;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_su <= n_su;
        r_lo <= n_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (push) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ou  <= r_su;
            r_orl <= push_rl;
            r_osl <= push_sl;
        end
    end

    assign o_in_stall        = (r_state != u8u16_pkg::ST_IDLE);
    assign o_out_valid       = r_ov;
    assign o_out_unit        = r_ou;
    assign o_out_run_last    = r_orl;
    assign o_out_stream_last = r_osl;

endmodule

@@ rtl/u8u16_win.sv @@
// four-byte window of held input bytes with append and front drop
// depends on u8u16_pkg
module u8u16_win (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [7:0]                 i_byte,
    input  logic                       i_drop,
    input  logic [u8u16_pkg::CNT_W-1:0] i_drop_n,
    output u8u16_pkg::t_win            o_bytes,
    output logic [u8u16_pkg::CNT_W-1:0] o_count
);

    u8u16_pkg::t_win               r_bytes;
    logic [u8u16_pkg::CNT_W-1:0]   r_count;

    // held bytes, no reset: only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (i_push && r_count < 3'd4) begin
            r_bytes[r_count[1:0]] <= i_byte;
        end else if (i_drop) begin
            case (i_drop_n)
                3'd1: r_bytes <= {8'h00, r_bytes[3:1]};
                3'd2: r_bytes <= {16'h0000, r_bytes[3:2]};
                3'd3: r_bytes <= {24'h000000, r_bytes[3]};
                default: r_bytes <= r_bytes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_push && r_count < 3'd4) begin
            r_count <= r_count + 3'd1;
        end else if (i_drop) begin
            if (i_drop_n >= r_count) begin
                r_count <= '0;
            end else begin
                r_count <= r_count - i_drop_n;
            end
        end
    end

    assign o_bytes = r_bytes;
    assign o_count = r_count;

endmodule

@@ rtl/u8u16_dec.sv @@
// decode unit: classifies the sequence at the window head and forms code units
// depends on u8u16_pkg
module u8u16_dec (
    input  u8u16_pkg::t_win             i_bytes,
    input  logic [u8u16_pkg::CNT_W-1:0] i_count,
    input  logic                        i_last,
    output u8u16_pkg::t_dec_res         o_res
);

    always_comb begin
        logic [7:0]  b0, b1, b2, b3;
        logic [2:0]  len;
        logic        cont_ok;
        logic        ok;
        logic [20:0] code;
        logic [20:0] s;

        b0 = i_bytes[0];
        b1 = i_bytes[1];
        b2 = i_bytes[2];
        b3 = i_bytes[3];

        if (!b0[7])                 len = 3'd1;
        else if (b0[7:5] == 3'b110) len = 3'd2;
        else if (b0[7:4] == 4'b1110) len = 3'd3;
        else if (b0[7:3] == 5'b11110) len = 3'd4;
        else                        len = 3'd0;

        unique case (len)
            3'd2: begin
                cont_ok = (b1[7:6] == 2'b10);
                code    = {10'd0, b0[4:0], b1[5:0]};
            end
            3'd3: begin
                cont_ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10);
                code    = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            end
            3'd4: begin
                cont_ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10)
                       && (b3[7:6] == 2'b10);
                code    = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            end
            default: begin
                cont_ok = 1'b1;
                code    = {13'd0, b0};
            end
        endcase

        ok = cont_ok;
        if ((len == 3'd2 && code < u8u16_pkg::C_MIN_LEN2) ||
            (len == 3'd3 && code < u8u16_pkg::C_MIN_LEN3) ||
            (len == 3'd4 && code < u8u16_pkg::C_SUPP_BASE)) begin
            ok = 1'b0;
        end
        if (code > u8u16_pkg::C_MAX_CP ||
            (code >= u8u16_pkg::C_SURR_MIN && code <= u8u16_pkg::C_SURR_MAX)) begin
            ok = 1'b0;
        end

        s = code - u8u16_pkg::C_SUPP_BASE;

        o_res.kind    = u8u16_pkg::K_EMIT1;
        o_res.unit    = u8u16_pkg::C_REPL;
        o_res.unit_lo = u8u16_pkg::C_SURR_LO + {6'd0, s[9:0]};
        o_res.drop    = 3'd1;

        if (i_count == 3'd0) begin
            o_res.kind = u8u16_pkg::K_EMPTY;
        end else if (len == 3'd0) begin
            // bad lead byte, drop it alone
            o_res.kind = u8u16_pkg::K_EMIT1;
        end else if (i_count < len) begin
            if (i_last) begin
                // truncated at end of string, drop everything held
                o_res.kind = u8u16_pkg::K_EMIT1;
                o_res.drop = i_count;
            end else begin
                o_res.kind = u8u16_pkg::K_WAIT;
            end
        end else if (!ok) begin
            o_res.kind = u8u16_pkg::K_EMIT1;
        end else if (code > 21'h00FFFF) begin
            o_res.kind = u8u16_pkg::K_EMIT2;
            o_res.unit = u8u16_pkg::C_SURR_HI + {6'd0, s[19:10]};
            o_res.drop = len;
        end else begin
            o_res.kind = u8u16_pkg::K_EMIT1;
            o_res.unit = code[15:0];
            o_res.drop = len;
        end
    end

endmodule

@@ rtl/u8u16_chk.sv @@
// port-level checker for the utf-8 to utf-16 lossy decoder, bound to the top level
// depends on utf8_to_utf16_lossy_decoder port names
module u8u16_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_in_byte,
    input logic        i_in_last,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_out_unit,
    input logic        o_out_run_last,
    input logic        o_out_stream_last
);

    // end of string always closes the run of its byte
    a_stream_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_stream_last) |-> o_out_run_last)
        else $error("stream_last without run_last");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_unit)
            && $stable(o_out_run_last) && $stable(o_out_stream_last)))
        else $error("stalled output word changed");

    // one byte at a time: the block works after taking a byte
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken on back-to-back cycles");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind utf8_to_utf16_lossy_decoder u8u16_chk u_chk (.*);

@@ verif/tb_top.sv @@
// testbench for the utf-8 to utf-16 lossy decoder: byte stream in, code units out
// depends on rtl/u8u16_pkg.sv and rtl/utf8_to_utf16_lossy_decoder.sv
`timescale 1ns / 100ps
module tb_top;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_WORDS = 400;
    // long receiver hold-off, so that the output register holds and the input stalls
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 60;
    // wait after the last expected word, for any passes still left over the window
    localparam int TAIL_CYCLES  = 24;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int PRINT_LIMIT  = 40;

    // one input word: a byte of the stream and its end-of-string flag
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_in_word;

    // one output word as the decoder must deliver it
    typedef struct {
        logic [15:0] unit;
        logic        run_last;
        logic        stream_last;
    } t_out_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_in_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_out_unit;
    logic        o_out_run_last;
    logic        o_out_stream_last;

    // bytes still to be offered, and code units the decoder still owes us
    t_in_word  words_to_send[$];
    t_out_word units_due[$];

    // predictor copy of the decoder window
    logic [7:0]  win_bytes [u8u16_pkg::WIN_DEPTH];
    int          win_count = 0;
    // code units produced by the byte being predicted
    logic [15:0] step_units [4];
    int          step_count;

    int bytes_taken = 0;
    int err_count   = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int send_idle_pct;
    int recv_stall_pct;

    utf8_to_utf16_lossy_decoder uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_byte         (i_in_byte),
        .i_in_last         (i_in_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_unit        (o_out_unit),
        .o_out_run_last    (o_out_run_last),
        .o_out_stream_last (o_out_stream_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // idling phases follow progress through the stream:
    // sender keen / receiver busy, then swapped, then full speed both ways
    always_comb begin
        if (bytes_taken < 140) begin
            send_idle_pct  = 28;
            recv_stall_pct = 79;
        end else if (bytes_taken < 280) begin
            send_idle_pct  = 79;
            recv_stall_pct = 28;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // decoder prediction
    // ---------------------------------------------------------------

    // record one code unit for the current byte; a fifth can not arise
    function automatic void note_unit(input logic [15:0] unit);
        if (step_count < 4) begin
            step_units[step_count] = unit;
            step_count++;
        end
    endfunction

    // drop k bytes from the window head, shifting the rest down
    function automatic void window_drop(input int k);
        if (k >= win_count) begin
            win_count = 0;
        end else begin
            for (int i = 0; i < win_count - k; i++)
                win_bytes[i] = win_bytes[i + k];
            win_count -= k;
        end
    endfunction

    // take one byte into the window and queue every code unit it releases
    function automatic void predict_byte(input logic [7:0] data, input logic last);
        logic [7:0]  lead;
        logic [20:0] cp;
        logic [20:0] ofs;
        int          len;
        logic        ok;
        logic        waiting;
        t_out_word   w;
        step_count = 0;
        waiting    = 1'b0;
        if (win_count < u8u16_pkg::WIN_DEPTH) begin
            win_bytes[win_count] = data;
            win_count++;
        end
        while (win_count > 0 && !waiting) begin
            lead = win_bytes[0];
            ok   = 1'b1;
            cp   = '0;
            // sequence length from the lead byte; zero marks a bad lead
            if (lead[7] == 1'b0) begin
                cp  = {14'd0, lead[6:0]};
                len = 1;
            end else if (lead[7:5] == 3'b110) begin
                cp  = {16'd0, lead[4:0]};
                len = 2;
            end else if (lead[7:4] == 4'b1110) begin
                cp  = {17'd0, lead[3:0]};
                len = 3;
            end else if (lead[7:3] == 5'b11110) begin
                cp  = {18'd0, lead[2:0]};
                len = 4;
            end else begin
                len = 0;
            end

            if (len == 0) begin
                // stray continuation or 0xf8-0xff lead
                note_unit(u8u16_pkg::C_REPL);
                window_drop(1);
            end else if (win_count < len) begin
                // short sequence: wait, or give one replacement at string end
                if (last) begin
                    note_unit(u8u16_pkg::C_REPL);
                    win_count = 0;
                end
                waiting = 1'b1;
            end else begin
                for (int k = 1; k < len; k++) begin
                    if (ok) begin
                        if (win_bytes[k][7:6] != 2'b10)
                            ok = 1'b0;
                        else
                            cp = {cp[14:0], win_bytes[k][5:0]};
                    end
                end
                // overlong forms, surrogate values and values past the last plane
                if (ok && ((len == 2 && cp < u8u16_pkg::C_MIN_LEN2) ||
                           (len == 3 && cp < u8u16_pkg::C_MIN_LEN3) ||
                           (len == 4 && cp < u8u16_pkg::C_SUPP_BASE) ||
                           cp > u8u16_pkg::C_MAX_CP ||
                           (cp >= u8u16_pkg::C_SURR_MIN && cp <= u8u16_pkg::C_SURR_MAX)))
                    ok = 1'b0;
                if (!ok) begin
                    // only the lead goes; the held bytes are decoded again
                    note_unit(u8u16_pkg::C_REPL);
                    window_drop(1);
                end else begin
                    if (cp <= 21'h00FFFF) begin
                        note_unit(cp[15:0]);
                    end else begin
                        ofs = cp - u8u16_pkg::C_SUPP_BASE;
                        note_unit(u8u16_pkg::C_SURR_HI + {6'd0, ofs[19:10]});
                        note_unit(u8u16_pkg::C_SURR_LO + {6'd0, ofs[9:0]});
                    end
                    window_drop(len);
                end
            end
        end
        for (int i = 0; i < step_count; i++) begin
            w.unit        = step_units[i];
            w.run_last    = (i == step_count - 1);
            w.stream_last = (i == step_count - 1) && last;
            units_due = {units_due, w};
        end
        if (last)
            win_count = 0;
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] data, input logic last);
        t_in_word w;
        w.data = data;
        w.last = last;
        words_to_send = {words_to_send, w};
    endtask

    // encode cp in len bytes (overlong if cp is small) and queue the first keep
    task automatic queue_encoded(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] enc [4];
        case (len)
            1: begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            queue_byte(enc[i], 1'b0);
    endtask

    // ---------------------------------------------------------------
    // input driver: offers queued bytes, predicts on every accepted word
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_in_word nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_byte(i_in_byte, i_in_last);
                bytes_taken <= bytes_taken + 1;
            end
            // a stalled word stays put; otherwise offer the next one or idle
            if (!i_in_valid || !o_in_stall) begin
                if (words_to_send.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = words_to_send.pop_front();
                    i_in_byte  <= nxt.data;
                    i_in_last  <= nxt.last;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off early in the run while the sender keeps going
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // output monitor: checks each accepted word against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (units_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected word unit=%h", o_out_unit));
                end else begin
                    want = units_due.pop_front();
                    if (o_out_unit !== want.unit)
                        report_mismatch($sformatf("unit got %h want %h",
                                                  o_out_unit, want.unit));
                    if (o_out_run_last !== want.run_last)
                        report_mismatch($sformatf("run_last got %b want %b (unit %h)",
                                                  o_out_run_last, want.run_last,
                                                  want.unit));
                    if (o_out_stream_last !== want.stream_last)
                        report_mismatch($sformatf("stream_last got %b want %b (unit %h)",
                                                  o_out_stream_last, want.stream_last,
                                                  want.unit));
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        // ascii extremes, smallest two-byte form, overlong two-byte form,
        // encoded surrogate, highest code point as a pair, value past the
        // last plane, bad continuation, two bad leads from the 0xf8-0xff range, and a
        // sequence cut short by the end of the string
        logic [7:0] directed [23] = '{
            8'h00, 8'h7F,
            8'hC2, 8'h80,
            8'hC0, 8'hAF,
            8'hED, 8'hA0, 8'h80,
            8'hF4, 8'h8F, 8'hBF, 8'hBF,
            8'hF4, 8'h90, 8'h80, 8'h80,
            8'hE2, 8'h41,
            8'hFF, 8'hF8,
            8'hE2, 8'h82
        };
        int          total;
        int          len;
        logic [20:0] cp;
        int          pick;

        foreach (directed[i])
            queue_byte(directed[i], i == $size(directed) - 1);

        // random part: mostly well-formed sequences, then invalid values,
        // truncated sequences and raw noise
        while (words_to_send.size() < $size(directed) + RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = $urandom_range(1, 4);
                case (len)
                    1: cp = 21'($urandom_range(0, 'h7F));
                    2: cp = 21'($urandom_range('h80, 'h7FF));
                    3: begin
                        cp = 21'($urandom_range('h800, 'hFFFF));
                        // steer clear of the surrogate block
                        if (cp >= u8u16_pkg::C_SURR_MIN && cp <= u8u16_pkg::C_SURR_MAX)
                            cp ^= 21'h001000;
                    end
                    default: cp = 21'($urandom_range('h10000, 'h10FFFF));
                endcase
                queue_encoded(cp, len, len);
            end else if (pick < 70) begin
                len = $urandom_range(2, 4);
                case ($urandom_range(0, 2))
                    0: begin
                        // overlong
                        if (len == 2)      cp = 21'($urandom_range(0, 'h7F));
                        else if (len == 3) cp = 21'($urandom_range(0, 'h7FF));
                        else               cp = 21'($urandom_range(0, 'hFFFF));
                    end
                    1: begin
                        len = 3;
                        cp  = 21'($urandom_range('hD800, 'hDFFF));
                    end
                    default: begin
                        len = 4;
                        cp  = 21'($urandom_range('h110000, 'h1FFFFF));
                    end
                endcase
                queue_encoded(cp, len, len);
            end else if (pick < 85) begin
                // truncated sequence, sometimes followed by a random byte
                len = $urandom_range(2, 4);
                cp  = 21'($urandom_range('h80, 'h10FFFF));
                queue_encoded(cp, len, $urandom_range(1, len - 1));
                if ($urandom_range(0, 1) == 1)
                    queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                repeat ($urandom_range(1, 3))
                    queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            // end the string here now and then
            if ($urandom_range(0, 7) == 0)
                words_to_send[words_to_send.size() - 1].last = 1'b1;
        end
        total = words_to_send.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < total || units_due.size() != 0)
            @(posedge i_clk);
        // let the decoder drain any replay passes; extra words are flagged
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/u8u16_pkg.sv
rtl/u8u16_win.sv
rtl/u8u16_dec.sv
rtl/utf8_to_utf16_lossy_decoder.sv
rtl/u8u16_chk.sv
verif/tb_top.sv
